FILE: rtl/sofa_pkg.sv
package sofa_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_CONFLICT = 2'd1;
    localparam t_status ST_NO_NET   = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_AUTO_ADDR = 1'd0;
    localparam t_cfg_idx CFG_AUTO_MASK = 1'd1;

    localparam logic [31:0] AUTO_ADDR_RST = 32'h0A00_0001;
    localparam logic [31:0] AUTO_MASK_RST = 32'hFF00_0000;

    typedef struct packed {
        logic        func;
        logic [15:0] alloc_size;
        logic        addr_type;
        logic [31:0] base_address;
        logic [31:0] base_mask;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic        new_entry;
        logic [31:0] granted_offset;
        logic [31:0] granted_base;
        logic [31:0] granted_mask;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] mask;
        logic        kind;
        logic [31:0] offset;
    } t_entry;

endpackage

FILE: rtl/sofa_table.sv
module sofa_table
    import sofa_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_entry,
    output logic             o_rd_valid,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_entry
);

    t_entry               mem [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_entry;
        end
        o_rd_entry <= mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            o_rd_valid <= r_valid[i_rd_idx];
        end
    end

endmodule

FILE: rtl/subnet_offset_allocator.sv
// Subnet offset allocator. Keeps up to TABLE_ENTRIES subnet entries in a
// synchronous table memory and serves one allocate request at a time; a result
// beat always follows every request beat. A request scans the table one entry
// per cycle. Automatic search repeats that scan once per network step, with
// states S_STEP_A and S_STEP_B forming the next network between scans. The
// next request beat is taken while the previous result still waits in the
// output register. No clearing pass after reset: entry valid bits sit in
// flip-flops.
module subnet_offset_allocator
    import sofa_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_data,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int STEP_W = $clog2(TABLE_ENTRIES + 2);
    localparam logic [CNT_W-1:0]  LAST_PTR  = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_STEP_A,
        S_STEP_B,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    t_in_beat          r_req, n_req;
    logic [31:0]       r_addr, n_addr;
    logic [31:0]       r_mask, n_mask;
    logic              r_kind, n_kind;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_cidx, n_cidx;
    logic              r_free_found, n_free_found;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    t_out_beat         r_res, n_res;
    logic              r_wr_en, n_wr_en;
    logic [IDX_W-1:0]  r_wr_idx, n_wr_idx;
    t_entry            r_wr_entry, n_wr_entry;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;
    logic [31:0]       r_auto_addr, r_auto_mask;

    t_entry            tbl_entry;
    logic              tbl_valid;
    logic              tbl_wr_en;
    logic              hit;
    logic              free_now;
    logic [IDX_W-1:0]  free_idx_now;
    logic [32:0]       sum;
    logic [31:0]       new_off;
    logic [31:0]       next_addr;
    logic              out_free;

    sofa_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_ptr[IDX_W-1:0]),
        .o_rd_entry (tbl_entry),
        .o_rd_valid (tbl_valid),
        .i_wr_en    (tbl_wr_en),
        .i_wr_idx   (r_wr_idx),
        .i_wr_entry (r_wr_entry)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign tbl_wr_en  = (r_state == S_FIN) && out_free && r_wr_en;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign hit = tbl_valid &&
                 ((tbl_entry.base & tbl_entry.mask) == (r_addr & r_mask));
    assign free_now     = r_free_found || !tbl_valid;
    assign free_idx_now = r_free_found ? r_free_idx : r_cidx;
    assign sum          = {1'b0, tbl_entry.offset} + 33'(r_req.alloc_size);
    assign new_off      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign next_addr    = r_addr + 32'd1;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_addr       = r_addr;
        n_mask       = r_mask;
        n_kind       = r_kind;
        n_steps      = r_steps;
        n_ptr        = r_ptr;
        n_pend       = 1'b0;
        n_cidx       = r_ptr[IDX_W-1:0];
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res        = r_res;
        n_wr_en      = r_wr_en;
        n_wr_idx     = r_wr_idx;
        n_wr_entry   = r_wr_entry;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req        = i_in_data;
                    n_addr       = i_in_data.func ? r_auto_addr : i_in_data.base_address;
                    n_mask       = i_in_data.func ? r_auto_mask : i_in_data.base_mask;
                    n_kind       = i_in_data.func ? 1'b0 : i_in_data.addr_type;
                    n_steps      = '0;
                    n_ptr        = '0;
                    n_free_found = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ptr < LAST_PTR) begin
                    n_ptr  = r_ptr + CNT_W'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    if (!tbl_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cidx;
                    end
                    n_res   = '0;
                    n_wr_en = 1'b0;
                    if (hit) begin
                        n_pend = 1'b0;
                        if (r_req.func) begin
                            if (r_steps > MAX_STEPS) begin
                                n_res.status = ST_NO_NET;
                                n_state      = S_FIN;
                            end else begin
                                n_steps = r_steps + STEP_W'(1);
                                n_state = S_STEP_A;
                            end
                        end else if (tbl_entry.kind != r_kind) begin
                            n_res.status = ST_CONFLICT;
                            n_state      = S_FIN;
                        end else begin
                            n_res.status         = ST_OK;
                            n_res.granted_offset = tbl_entry.offset;
                            n_res.granted_base   = tbl_entry.base;
                            n_res.granted_mask   = tbl_entry.mask;
                            n_wr_en              = 1'b1;
                            n_wr_idx             = r_cidx;
                            n_wr_entry.base      = r_addr;
                            n_wr_entry.mask      = r_mask;
                            n_wr_entry.kind      = tbl_entry.kind;
                            n_wr_entry.offset    = new_off;
                            n_state              = S_FIN;
                        end
                    end else if (r_cidx == LAST_IDX) begin
                        n_pend = 1'b0;
                        if (free_now) begin
                            n_res.status       = ST_OK;
                            n_res.new_entry    = 1'b1;
                            n_res.granted_base = r_addr;
                            n_res.granted_mask = r_mask;
                            n_wr_en            = 1'b1;
                            n_wr_idx           = free_idx_now;
                            n_wr_entry.base    = r_addr;
                            n_wr_entry.mask    = r_mask;
                            n_wr_entry.kind    = r_kind;
                            n_wr_entry.offset  = 32'(r_req.alloc_size);
                        end else begin
                            n_res.status = ST_FULL;
                        end
                        n_state = S_FIN;
                    end
                end
            end
            S_STEP_A: begin
                n_addr  = (r_addr + ~r_mask + 32'd1) & r_mask;
                n_state = S_STEP_B;
            end
            S_STEP_B: begin
                n_addr = next_addr;
                if ((next_addr & r_mask) == 32'd0) begin
                    n_res        = '0;
                    n_res.status = ST_NO_NET;
                    n_wr_en      = 1'b0;
                    n_state      = S_FIN;
                end else begin
                    n_ptr        = '0;
                    n_free_found = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_free_found <= 1'b0;
            r_wr_en      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_steps      <= '0;
            r_ptr        <= '0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_free_found <= n_free_found;
            r_wr_en      <= n_wr_en;
            r_out_valid  <= n_out_valid;
            r_steps      <= n_steps;
            r_ptr        <= n_ptr;
        end
        r_req      <= n_req;
        r_addr     <= n_addr;
        r_mask     <= n_mask;
        r_kind     <= n_kind;
        r_cidx     <= n_cidx;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        r_wr_idx   <= n_wr_idx;
        r_wr_entry <= n_wr_entry;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_addr <= AUTO_ADDR_RST;
            r_auto_mask <= AUTO_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AUTO_ADDR: r_auto_addr <= i_cfg_data;
                CFG_AUTO_MASK: r_auto_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/sofa_checker.sv
module sofa_checker
    import sofa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_beat    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_beat   o_out_data,
    input logic        i_cfg_we,
    input t_cfg_idx    i_cfg_idx,
    input logic [31:0] i_cfg_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // error results carry no grant
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            !o_out_data.new_entry && (o_out_data.granted_offset == 32'd0) &&
            (o_out_data.granted_base == 32'd0) && (o_out_data.granted_mask == 32'd0))
        else $error("error result with nonzero grant");

    // a fresh entry starts at offset zero
    a_new_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.new_entry |->
            (o_out_data.status == ST_OK) && (o_out_data.granted_offset == 32'd0))
        else $error("new entry with nonzero offset");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

endmodule

bind subnet_offset_allocator sofa_checker u_sofa_checker (.*);

FILE: verif/subnet_offset_allocator_checker.sv
module subnet_offset_allocator_checker
    import sofa_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_beat   i_out_data,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_new_entries,
    output int          o_conflicts,
    output int          o_no_net,
    output int          o_full,
    output int          o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        slot_used [TABLE_ENTRIES];
    t_entry      slot [TABLE_ENTRIES];
    logic [31:0] search_addr;
    logic [31:0] search_mask;
    t_out_beat   grants [$];
    t_out_beat   want;
    t_out_beat   fresh;

    int n_errors = 0;
    int n_new = 0;
    int n_conflicts = 0;
    int n_no_net = 0;
    int n_full = 0;
    int n_sat = 0;

    assign o_errors      = n_errors;
    assign o_new_entries = n_new;
    assign o_conflicts   = n_conflicts;
    assign o_no_net      = n_no_net;
    assign o_full        = n_full;
    assign o_saturated   = n_sat;

    function automatic int owner_of(logic [31:0] addr, logic [31:0] mask);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i] && (slot[i].base & slot[i].mask) == (addr & mask))
                return i;
        end
        return -1;
    endfunction

    function automatic int first_spare();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!slot_used[i])
                return i;
        end
        return -1;
    endfunction

    // Updates the table copy and returns the grant for one request.
    function automatic t_out_beat grant_for(t_in_beat rq);
        t_out_beat   res;
        logic [31:0] addr;
        logic [31:0] mask;
        logic        kind;
        logic [32:0] sum;
        logic        failed;
        int          hops;
        int          hit;
        int          spare;
        res    = '0;
        addr   = rq.base_address;
        mask   = rq.base_mask;
        kind   = rq.addr_type;
        failed = 1'b0;
        hops   = 0;
        if (rq.func) begin
            kind = 1'b0;
            addr = search_addr;
            mask = search_mask;
            while (!failed && owner_of(addr, mask) >= 0) begin
                if (hops > TABLE_ENTRIES) begin
                    failed = 1'b1;
                end else begin
                    hops++;
                    addr = ((addr + (~mask + 32'd1)) & mask) + 32'd1;
                    if ((addr & mask) == 32'd0)
                        failed = 1'b1;
                end
            end
            if (failed)
                res.status = ST_NO_NET;
        end
        if (!failed) begin
            hit = owner_of(addr, mask);
            if (hit >= 0) begin
                if (slot[hit].kind != kind) begin
                    res.status = ST_CONFLICT;
                end else begin
                    res.granted_offset = slot[hit].offset;
                    res.granted_base   = slot[hit].base;
                    res.granted_mask   = slot[hit].mask;
                    sum = {1'b0, slot[hit].offset} + {17'd0, rq.alloc_size};
                    if (sum[32]) begin
                        slot[hit].offset = '1;
                        n_sat++;
                    end else begin
                        slot[hit].offset = sum[31:0];
                    end
                    slot[hit].base = addr;
                    slot[hit].mask = mask;
                end
            end else begin
                spare = first_spare();
                if (spare < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_used[spare]   = 1'b1;
                    slot[spare].base   = addr;
                    slot[spare].mask   = mask;
                    slot[spare].kind   = kind;
                    slot[spare].offset = {16'd0, rq.alloc_size};
                    res.new_entry      = 1'b1;
                    res.granted_base   = addr;
                    res.granted_mask   = mask;
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_used[i] = 1'b0;
            search_addr = AUTO_ADDR_RST;
            search_mask = AUTO_MASK_RST;
            grants.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AUTO_ADDR: search_addr = i_cfg_data;
                    CFG_AUTO_MASK: search_mask = i_cfg_data;
                endcase
            end
            // result side first: a beat leaving now never belongs to a request taken now
            if (i_out_valid && !i_out_stall) begin
                if (grants.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 40)
                        $display("%0t: unexpected result beat, expected none, got %h",
                                 $time, i_out_data);
                end else begin
                    want = grants.pop_front();
                    check_field("status", 32'(want.status), 32'(i_out_data.status));
                    check_field("new_entry", 32'(want.new_entry), 32'(i_out_data.new_entry));
                    check_field("granted_offset", want.granted_offset,
                                i_out_data.granted_offset);
                    check_field("granted_base", want.granted_base, i_out_data.granted_base);
                    check_field("granted_mask", want.granted_mask, i_out_data.granted_mask);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh = grant_for(i_in_data);
                case (fresh.status)
                    ST_CONFLICT: n_conflicts++;
                    ST_NO_NET:   n_no_net++;
                    ST_FULL:     n_full++;
                    default:     ;
                endcase
                if (fresh.new_entry)
                    n_new++;
                grants = {grants, fresh};
            end
            o_pending <= grants.size();
        end
    end

endmodule

FILE: verif/tb_subnet_offset_allocator.sv
module tb_subnet_offset_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import sofa_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int SOAK_BEATS   = 64;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 145;
    localparam int DRAIN_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    t_in_beat    req = '0;
    logic        grant_valid;
    logic        grant_stall = 1'b0;
    t_out_beat   grant;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_AUTO_ADDR;
    logic [31:0] cfg_data = '0;

    int errors;
    int pending;
    int new_cnt;
    int conflict_cnt;
    int no_net_cnt;
    int full_cnt;
    int sat_cnt;

    logic quiet = 1'b0;
    int   hold = 0;
    int   n_sent = 0;
    int   n_auto = 0;
    int   n_settings = 1;

    logic [31:0] known_net [$];
    logic [31:0] known_mask [$];
    logic        known_kind [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    subnet_offset_allocator #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in_data  (req),
        .o_out_valid(grant_valid),
        .i_out_stall(grant_stall),
        .o_out_data (grant),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    subnet_offset_allocator_checker #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_in_data    (req),
        .i_out_valid  (grant_valid),
        .i_out_stall  (grant_stall),
        .i_out_data   (grant),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_new_entries(new_cnt),
        .o_conflicts  (conflict_cnt),
        .o_no_net     (no_net_cnt),
        .o_full       (full_cnt),
        .o_saturated  (sat_cnt)
    );

    // result side: after each taken beat, stall for a random number of cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            grant_stall <= 1'b0;
            hold <= 0;
        end else if (grant_valid && !grant_stall) begin
            hold <= quiet ? 0 : $urandom_range(0, 9);
        end else if (hold != 0) begin
            hold <= hold - 1;
            grant_stall <= 1'b1;
        end else begin
            grant_stall <= 1'b0;
        end
    end

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'd0 : (~32'd0) << (32 - len);
    endfunction

    function automatic t_in_beat make_req(logic func, logic [15:0] size, logic kind,
                                          logic [31:0] addr, logic [31:0] mask);
        t_in_beat r;
        r.func         = func;
        r.alloc_size   = size;
        r.addr_type    = kind;
        r.base_address = addr;
        r.base_mask    = mask;
        return r;
    endfunction

    // mostly requests on networks already seen, plus searches and fresh networks
    function automatic t_in_beat random_req();
        t_in_beat r;
        int       pick;
        int       k;
        int       s;
        s = $urandom_range(0, 9);
        r.func         = 1'b0;
        r.alloc_size   = (s == 0) ? 16'd0 : (s == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        r.addr_type    = 1'($urandom_range(0, 1));
        r.base_address = $urandom;
        r.base_mask    = prefix_mask($urandom_range(0, 32));
        pick = $urandom_range(0, 99);
        if (pick < 55 && known_net.size() != 0) begin
            k = $urandom_range(0, known_net.size() - 1);
            r.base_mask    = known_mask[k];
            r.base_address = known_net[k] | ($urandom & ~known_mask[k]);
            if ($urandom_range(0, 3) != 0)
                r.addr_type = known_kind[k];
        end else if (pick < 75) begin
            r.func = 1'b1;
        end else if (pick < 85) begin
            r.base_address = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            r.base_mask    = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end else if (pick < 90) begin
            r.base_mask = $urandom;
        end
        return r;
    endfunction

    task automatic send(input t_in_beat b);
        int   gap;
        logic seen;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= b;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        n_sent++;
        if (b.func) begin
            n_auto++;
        end else begin
            seen = 1'b0;
            for (int i = 0; i < known_net.size(); i++) begin
                if (known_net[i] == (b.base_address & b.base_mask) &&
                    known_mask[i] == b.base_mask)
                    seen = 1'b1;
            end
            if (!seen) begin
                known_net  = {known_net, b.base_address & b.base_mask};
                known_mask = {known_mask, b.base_mask};
                known_kind = {known_kind, b.addr_type};
                if (known_net.size() > 64) begin
                    void'(known_net.pop_front());
                    void'(known_mask.pop_front());
                    void'(known_kind.pop_front());
                end
            end
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_search(logic [31:0] addr, logic [31:0] mask);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_AUTO_ADDR;
        cfg_data <= addr;
        @(posedge clk);
        cfg_idx <= CFG_AUTO_MASK;
        cfg_data <= mask;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reallocation, conflicts, extremes, automatic search
        send(make_req(1'b0, 16'd0, 1'b0, 32'hC0A8_0001, 32'hFFFF_FF00));
        send(make_req(1'b0, 16'hFFFF, 1'b0, 32'hC0A8_00FE, 32'hFFFF_FF00));
        send(make_req(1'b0, 16'd3, 1'b1, 32'hC0A8_0010, 32'hFFFF_FF00));
        send(make_req(1'b1, 16'd100, 1'b1, 32'hDEAD_BEEF, 32'h0000_FFFF));
        send(make_req(1'b1, 16'd1, 1'b0, 32'h0, 32'h0));
        send(make_req(1'b0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_req(1'b0, 16'd9, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_req(1'b0, 16'd20, 1'b0, 32'h0B12_3456, 32'hFF00_0000));
        send(make_req(1'b0, 16'd7, 1'b1, 32'h0, 32'h0));
        send(make_req(1'b0, 16'd2, 1'b1, 32'h1234_5678, 32'h0));
        send(make_req(1'b0, 16'd2, 1'b0, 32'h1234_5678, 32'h0));
        // search that wraps to network zero
        drain();
        set_search(32'hFF00_0001, 32'hFF00_0000);
        send(make_req(1'b1, 16'd4, 1'b0, 32'h0, 32'h0));
        send(make_req(1'b1, 16'd4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // split mask: search cycles between two taken networks until it gives up
        send(make_req(1'b0, 16'd1, 1'b0, 32'h8000_0001, 32'h8000_0001));
        send(make_req(1'b0, 16'd1, 1'b0, 32'h0000_0001, 32'h8000_0001));
        drain();
        set_search(32'h8000_0001, 32'h8000_0001);
        send(make_req(1'b1, 16'd5, 1'b0, 32'h0, 32'h0));
        drain();
        set_search(32'h0, 32'h0);
        send(make_req(1'b1, 16'd5, 1'b0, 32'h0, 32'h0));
        drain();
        set_search(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(make_req(1'b1, 16'hFFFF, 1'b0, 32'h0, 32'h0));
        // fill the table, last one overflows
        for (k = 0; k < 8; k++)
            send(make_req(1'b0, 16'($urandom_range(0, 65535)), 1'(k),
                          32'h6400_0000 | (k << 16), 32'hFFFF_0000));

        // soak one subnet with back-to-back large allocations, then eight of random size
        drain();
        quiet = 1'b1;
        for (k = 0; k < SOAK_BEATS; k++)
            send(make_req(1'b0, (k < SOAK_BEATS - 8) ? 16'hFFFF : 16'($urandom),
                          1'b0, 32'hC0A8_0000 | $urandom_range(0, 255), 32'hFFFF_FF00));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: set_search(32'h0, 32'h0);
                1: set_search(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_search(AUTO_ADDR_RST, AUTO_MASK_RST);
                3: set_search(32'h8000_0001, 32'h8000_0001);
                default: begin
                    k = $urandom_range(0, known_net.size() - 1);
                    set_search(known_net[k] | 32'd1, known_mask[k]);
                end
            endcase
            quiet = (p == 1 || p == 4);
            for (int j = 0; j < PHASE_BEATS; j++)
                send(random_req());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d allocate beats (%0d automatic searches, %0d on one soaked subnet)",
                 n_sent, n_auto, SOAK_BEATS);
        $display("across %0d search settings: %0d new entries, %0d conflicts, %0d no network,"
                 , n_settings, new_cnt, conflict_cnt, no_net_cnt);
        $display("%0d table full, %0d saturating adds", full_cnt, sat_cnt);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
